FILE: rtl/core/integer_alu_with_extended_gcd_top_assert.svh
// assertion macros for the integer alu with extended gcd
`ifndef INTEGER_ALU_WITH_EXTENDED_GCD_TOP_ASSERT_SVH
`define INTEGER_ALU_WITH_EXTENDED_GCD_TOP_ASSERT_SVH

// same-cycle implication
`define IGA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("iga assertion failed");

// next-cycle implication
`define IGA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("iga assertion failed");

`endif

FILE: rtl/core/iga_pkg.sv
// ----------------------------------------------------------------------------
// iga_pkg
// types and codes shared by the integer alu with extended gcd
// ----------------------------------------------------------------------------
package iga_pkg;

   localparam logic [3:0] OP_ADD    = 4'd0;
   localparam logic [3:0] OP_SUB    = 4'd1;
   localparam logic [3:0] OP_MUL    = 4'd2;
   localparam logic [3:0] OP_DIV    = 4'd3;
   localparam logic [3:0] OP_MOD    = 4'd4;
   localparam logic [3:0] OP_DIVMOD = 4'd5;
   localparam logic [3:0] OP_EUCLID = 4'd6;
   localparam logic [3:0] OP_AND    = 4'd7;
   localparam logic [3:0] OP_XOR    = 4'd8;
   localparam logic [3:0] OP_OR     = 4'd9;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SIMPLE,
      S_ABSA,
      S_ABSB,
      S_DIV,
      S_FIXQ,
      S_FIXR,
      S_MUL,
      S_MULP,
      S_MULQ,
      S_EMIT
   } iga_state_type;

endpackage

FILE: rtl/core/iga_if.sv
// ----------------------------------------------------------------------------
// iga request and response channels
// valid/ready channels carrying the alu request and result words
// ----------------------------------------------------------------------------
interface iga_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] operand_a;
   logic signed [31:0] operand_b;
   logic        [3:0]  operation;

   modport source (output valid, output operand_a, output operand_b, output operation,
                   input ready);
   modport sink   (input valid, input operand_a, input operand_b, input operation,
                   output ready);
endinterface

interface iga_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;
   logic               status;
   logic               last;

   modport source (output valid, output value, output status, output last, input ready);
   modport sink   (input valid, input value, input status, input last, output ready);
endinterface

FILE: rtl/core/iga_addsub.sv
// ----------------------------------------------------------------------------
// iga_addsub
// shared add/subtract unit used by the arithmetic steps of the sequencer
// ----------------------------------------------------------------------------
module iga_addsub
   import iga_pkg::*;
#(
   parameter int DATA_WIDTH = 64
) (
   input  logic [DATA_WIDTH-1:0] x,
   input  logic [DATA_WIDTH-1:0] y,
   input  logic                  sub,
   output logic [DATA_WIDTH-1:0] sum
);

   assign sum = x + (sub ? ~y : y) + DATA_WIDTH'(sub);

endmodule

FILE: rtl/core/integer_alu_with_extended_gcd_top.sv
// ----------------------------------------------------------------------------
// integer_alu_with_extended_gcd_top
// integer alu (add, sub, mul, div, mod, divmod, and, xor, or) with an
// extended euclid run, built around one shared adder under a sequencer
// ----------------------------------------------------------------------------
//  channel  | dir | payload                          | handshake
//  req_if   | in  | operand_a, operand_b, operation  | valid/ready
//  rsp_if   | out | value, status, last               | valid/ready
//
//  add/sub/logic: simple state, then emit; mul: |b|, then a shift-add loop;
//  div/mod/divmod: |a|, |b|, a radix-2 restoring divide loop, quotient and
//  remainder sign fixes; euclid: each division step runs the divide and two
//  shift-add multiplies, steps depend on the data, then result words in order
//  reset is synchronous; the response register holds a word until taken, and
//  the sequencer stays in emit while a word is held and rsp_if.ready is low
// ----------------------------------------------------------------------------
module integer_alu_with_extended_gcd_top
   import iga_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   iga_req_if.sink    req_if,
   iga_rsp_if.source  rsp_if
);
   `include "integer_alu_with_extended_gcd_top_assert.svh"

   localparam int W  = OPERAND_WIDTH;
   localparam int DW = 2 * OPERAND_WIDTH;
   localparam int CW = $clog2(OPERAND_WIDTH);

   iga_state_type state_ff, state_in;

   logic        [3:0]    op_ff;
   logic                 err_ff;
   logic signed [W-1:0]  x_ff, y_ff;
   logic signed [DW-1:0] p1_ff, p2_ff, q1_ff, q2_ff;
   logic        [W-1:0]  amag_ff, dmag_ff, rem_ff;
   logic signed [W:0]    quo_ff;
   logic signed [W-1:0]  rmd_ff;
   logic signed [DW-1:0] acc_ff, mcand_ff;
   logic                 msub_ff;
   logic        [CW-1:0] cnt_ff;
   logic        [2:0]    idx_ff;

   logic                 rsp_valid_ff;
   logic signed [63:0]   rsp_value_ff;
   logic                 rsp_status_ff, rsp_last_ff;

   logic            [DW-1:0] add_x, add_y, add_sum;
   logic                     add_sub;
   logic                     accept, load, cnt_last, is_div, req_bzero;
   logic            [W-1:0]  req_a, req_b;
   logic signed     [DW-1:0] acc_next;
   logic            [2:0]    last_idx;
   logic signed     [63:0]   word_value;

   iga_addsub #(.DATA_WIDTH(DW)) u_addsub (
      .x   (add_x),
      .y   (add_y),
      .sub (add_sub),
      .sum (add_sum)
   );

   assign req_a     = req_if.operand_a[W-1:0];
   assign req_b     = req_if.operand_b[W-1:0];
   assign accept    = req_if.valid && req_if.ready;
   assign is_div    = (req_if.operation == OP_DIV) || (req_if.operation == OP_MOD) ||
                      (req_if.operation == OP_DIVMOD) || (req_if.operation == OP_EUCLID);
   assign req_bzero = (req_b == '0);
   assign cnt_last  = (cnt_ff == CW'(W - 1));
   assign load      = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_if.ready);
   assign acc_next  = dmag_ff[0] ? $signed(add_sum) : acc_ff;

   // shared adder operand selection
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         S_SIMPLE: begin
            add_x   = DW'(x_ff);
            add_y   = DW'(y_ff);
            add_sub = (op_ff == OP_SUB);
         end
         S_ABSA: begin
            add_y   = DW'(x_ff);
            add_sub = x_ff[W-1];
         end
         S_ABSB: begin
            add_y   = DW'(y_ff);
            add_sub = y_ff[W-1];
         end
         S_DIV: begin
            add_x   = DW'({rem_ff, amag_ff[W-1]});
            add_y   = DW'(dmag_ff);
            add_sub = 1'b1;
         end
         S_FIXQ: begin
            add_y   = DW'(amag_ff);
            add_sub = x_ff[W-1] ^ y_ff[W-1];
         end
         S_FIXR: begin
            add_y   = DW'(rem_ff);
            add_sub = x_ff[W-1];
         end
         S_MUL, S_MULP, S_MULQ: begin
            add_x   = acc_ff;
            add_y   = mcand_ff;
            add_sub = msub_ff;
         end
         default: begin
            add_x   = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_if.operation > OP_OR)     state_in = S_IDLE;
               else if (is_div && req_bzero)     state_in = S_EMIT;
               else if (req_if.operation == OP_MUL) state_in = S_ABSB;
               else if (is_div)                  state_in = S_ABSA;
               else                              state_in = S_SIMPLE;
            end
         end
         S_SIMPLE: state_in = S_EMIT;
         S_ABSA:   state_in = S_ABSB;
         S_ABSB:   state_in = (op_ff == OP_MUL) ? S_MUL : S_DIV;
         S_DIV:    if (cnt_last) state_in = S_FIXQ;
         S_FIXQ:   state_in = S_FIXR;
         S_FIXR:   state_in = (op_ff == OP_EUCLID) ? S_MULP : S_EMIT;
         S_MUL:    if (cnt_last) state_in = S_EMIT;
         S_MULP:   if (cnt_last) state_in = S_MULQ;
         S_MULQ:   if (cnt_last) state_in = (rmd_ff == '0) ? S_EMIT : S_ABSA;
         S_EMIT:   if (load && idx_ff == last_idx) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.value  = rsp_value_ff;
   assign rsp_if.status = rsp_status_ff;
   assign rsp_if.last   = rsp_last_ff;

   always_comb begin
      last_idx = 3'd0;
      if (!err_ff && op_ff == OP_DIVMOD) last_idx = 3'd1;
      if (!err_ff && op_ff == OP_EUCLID) last_idx = 3'd5;
   end

   always_comb begin
      word_value = 64'(acc_ff);
      if (err_ff) begin
         word_value = '0;
      end else begin
         priority case (op_ff)
            OP_DIV:    word_value = 64'(quo_ff);
            OP_MOD:    word_value = 64'(rmd_ff);
            OP_DIVMOD: word_value = (idx_ff == 3'd0) ? 64'(quo_ff) : 64'(rmd_ff);
            OP_EUCLID: begin
               priority case (idx_ff)
                  3'd0:    word_value = 64'(x_ff);
                  3'd1:    word_value = 64'(y_ff);
                  3'd2:    word_value = 64'(p1_ff);
                  3'd3:    word_value = 64'(p2_ff);
                  3'd4:    word_value = 64'(q1_ff);
                  default: word_value = 64'(q2_ff);
               endcase
            end
            default:   word_value = 64'(acc_ff);
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load)              rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_value_ff  <= word_value;
         rsp_status_ff <= err_ff;
         rsp_last_ff   <= (idx_ff == last_idx);
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_ff   <= req_a;
               y_ff   <= req_b;
               op_ff  <= req_if.operation;
               err_ff <= is_div && req_bzero;
               p1_ff  <= DW'(1);
               p2_ff  <= '0;
               q1_ff  <= '0;
               q2_ff  <= DW'(1);
               idx_ff <= '0;
            end
         end
         S_SIMPLE: begin
            priority case (op_ff)
               OP_AND:  acc_ff <= DW'(x_ff & y_ff);
               OP_XOR:  acc_ff <= DW'(x_ff ^ y_ff);
               OP_OR:   acc_ff <= DW'(x_ff | y_ff);
               default: acc_ff <= add_sum;
            endcase
         end
         S_ABSA: amag_ff <= add_sum[W-1:0];
         S_ABSB: begin
            dmag_ff  <= add_sum[W-1:0];
            rem_ff   <= '0;
            cnt_ff   <= '0;
            acc_ff   <= '0;
            mcand_ff <= DW'(x_ff);
            msub_ff  <= y_ff[W-1];
         end
         S_DIV: begin
            // restoring step: keep the trial difference when it is not negative
            if (!add_sum[DW-1]) begin
               rem_ff  <= add_sum[W-1:0];
               amag_ff <= {amag_ff[W-2:0], 1'b1};
            end else begin
               rem_ff  <= {rem_ff[W-2:0], amag_ff[W-1]};
               amag_ff <= {amag_ff[W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
         S_FIXQ: quo_ff <= add_sum[W:0];
         S_FIXR: begin
            rmd_ff   <= add_sum[W-1:0];
            acc_ff   <= p1_ff;
            mcand_ff <= p2_ff;
            dmag_ff  <= amag_ff;
            msub_ff  <= !(x_ff[W-1] ^ y_ff[W-1]);
            cnt_ff   <= '0;
         end
         S_MUL, S_MULP, S_MULQ: begin
            if (cnt_last && state_ff == S_MULP) begin
               p1_ff    <= p2_ff;
               p2_ff    <= acc_next;
               acc_ff   <= q1_ff;
               mcand_ff <= q2_ff;
               dmag_ff  <= amag_ff;
               cnt_ff   <= '0;
            end else begin
               acc_ff   <= acc_next;
               mcand_ff <= mcand_ff <<< 1;
               dmag_ff  <= dmag_ff >> 1;
               cnt_ff   <= cnt_ff + 1'b1;
            end
            if (cnt_last && state_ff == S_MULQ) begin
               q1_ff <= q2_ff;
               q2_ff <= acc_next;
               x_ff  <= y_ff;
               y_ff  <= rmd_ff;
            end
         end
         S_EMIT: begin
            if (load) idx_ff <= idx_ff + 1'b1;
         end
         default: begin
            idx_ff <= idx_ff;
         end
      endcase
   end

   `IGA_ASSERT_NEXT(a_bad_op_idle,
      accept && (req_if.operation > OP_OR), state_ff == S_IDLE)
   `IGA_ASSERT_NOW(a_err_word,
      rsp_if.valid && rsp_if.status, rsp_if.last && (rsp_if.value == '0))
   `IGA_ASSERT_NOW(a_div_nonzero,
      state_ff == S_DIV, dmag_ff != '0)

endmodule
